/* rtl/psfc_pkg.sv */
package psfc_pkg;

    localparam int unsigned FRAME_LEN = 16;
    localparam int unsigned IDX_W = 5;

    localparam logic [15:0] CRC_POLY = 16'h8005;
    localparam logic [15:0] CRC_INIT = 16'h8181;
    localparam logic [15:0] FRAME_TYPE = 16'hFF60;

    localparam logic [IDX_W-1:0] IDX_TYPE_HI = 5'd0;
    localparam logic [IDX_W-1:0] IDX_TYPE_LO = 5'd1;
    localparam logic [IDX_W-1:0] IDX_COUNT_LO = 5'd4;
    localparam logic [IDX_W-1:0] IDX_COUNT_HI = 5'd5;
    localparam logic [IDX_W-1:0] IDX_ID_HI = 5'd6;
    localparam logic [IDX_W-1:0] IDX_ID_MID = 5'd7;
    localparam logic [IDX_W-1:0] IDX_ID_LO = 5'd8;
    localparam logic [IDX_W-1:0] IDX_ALARM = 5'd12;
    localparam logic [IDX_W-1:0] IDX_FULL = 5'd16;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_SHORT = 2'd1;
    localparam logic [1:0] STATUS_CRC = 2'd2;
    localparam logic [1:0] STATUS_TYPE = 2'd3;

    typedef struct packed {
        logic        short_frame;
        logic [15:0] crc;
        logic [15:0] type_word;
        logic [23:0] id;
        logic [15:0] count_raw;
        logic [7:0]  alarm;
    } frame_sum_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] sensor_id;
        logic [15:0] event_count;
        logic        tamper;
        logic        motion;
        logic        battery_good;
    } result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] bit_rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

    function automatic logic [15:0] gray16(input logic [15:0] g);
        logic [15:0] b;
        for (int i = 0; i < 16; i++) begin
            b[i] = ^(g >> i);
        end
        return b;
    endfunction

    function automatic logic [3:0] gray4(input logic [3:0] g);
        logic [3:0] b;
        for (int i = 0; i < 4; i++) begin
            b[i] = ^(g >> i);
        end
        return b;
    endfunction

endpackage

/* rtl/psfc_frame_acc.sv */
module psfc_frame_acc
    import psfc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       frame_end,
    output frame_sum_t frame_sum
);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] type_reg, type_next;
    logic [23:0] id_reg, id_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  alarm_reg, alarm_next;

    always_comb begin
        idx_next = idx_reg;
        crc_next = crc_reg;
        type_next = type_reg;
        id_next = id_reg;
        count_next = count_reg;
        alarm_next = alarm_reg;
        if (idx_reg < IDX_FULL) begin
            crc_next = crc_byte(crc_reg, data_byte);
            idx_next = idx_reg + 1'b1;
            case (idx_reg)
                IDX_TYPE_HI:  type_next[15:8] = data_byte;
                IDX_TYPE_LO:  type_next[7:0] = data_byte;
                IDX_COUNT_LO: count_next[7:0] = bit_rev8(data_byte);
                IDX_COUNT_HI: count_next[15:8] = bit_rev8(data_byte);
                IDX_ID_HI:    id_next[23:16] = data_byte;
                IDX_ID_MID:   id_next[15:8] = data_byte;
                IDX_ID_LO:    id_next[7:0] = data_byte;
                IDX_ALARM:    alarm_next = bit_rev8(data_byte);
                default: ;
            endcase
        end
    end

    assign frame_sum.short_frame = (idx_next < IDX_FULL);
    assign frame_sum.crc = crc_next;
    assign frame_sum.type_word = type_next;
    assign frame_sum.id = id_next;
    assign frame_sum.count_raw = count_next;
    assign frame_sum.alarm = alarm_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && frame_end)) begin
            idx_reg <= '0;
            crc_reg <= CRC_INIT;
            type_reg <= '0;
            id_reg <= '0;
            count_reg <= '0;
            alarm_reg <= '0;
        end else if (step) begin
            idx_reg <= idx_next;
            crc_reg <= crc_next;
            type_reg <= type_next;
            id_reg <= id_next;
            count_reg <= count_next;
            alarm_reg <= alarm_next;
        end
    end

endmodule

/* rtl/psfc_result_reg.sv */
module psfc_result_reg
    import psfc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  frame_sum_t frame_sum,
    input  logic       m_tready,
    output logic       m_tvalid,
    output result_t    result
);

    result_t    res_next;
    result_t    res_reg;
    logic       valid_reg;
    logic [3:0] lo_bin;
    logic [3:0] hi_bin;

    always_comb begin
        lo_bin = gray4(frame_sum.alarm[3:0]);
        hi_bin = gray4(frame_sum.alarm[7:4]);
        res_next = '0;
        if (frame_sum.short_frame) begin
            res_next.status = STATUS_SHORT;
        end else if (frame_sum.crc != 16'h0000) begin
            res_next.status = STATUS_CRC;
        end else if (frame_sum.type_word != FRAME_TYPE) begin
            res_next.status = STATUS_TYPE;
        end else begin
            res_next.status = STATUS_OK;
            res_next.sensor_id = frame_sum.id;
            res_next.event_count = gray16(frame_sum.count_raw);
            res_next.tamper = lo_bin[2];
            res_next.motion = lo_bin[1];
            res_next.battery_good = ~hi_bin[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign result = res_reg;

endmodule

/* rtl/pir_sensor_frame_checker.sv */
// Channel | Direction | tdata (low bit up)                               | tlast
// s_      | in        | data_byte[7:0]                                   | frame_end
// m_      | out       | status, sensor_id, event_count, tamper, motion,  | -
//         |           | battery_good, 3 zero bits (48 bits)              |
//
// One byte is taken per cycle while s_tready is high; it is held in the input
// register, then the CRC-16 byte step and field capture update the frame state.
// The last byte of a frame loads the result register as it steps out of the
// input register, and the loaded result register raises m_tvalid.
// Reset is synchronous on aresetn and returns the frame state to its start.
// A stalled result register holds the input register, then s_tready.
module pir_sensor_frame_checker
    import psfc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status[1:0], sensor_id[25:2], event_count[41:26],
                                   // tamper[42], motion[43], battery_good[44], zero[47:45]
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       adv;
    logic       step;
    frame_sum_t frame_sum;
    result_t    result;

    assign adv = !m_tvalid || m_tready;
    assign step = in_valid_reg && adv;
    assign s_tready = adv || !in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    psfc_frame_acc u_acc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .data_byte (in_byte_reg),
        .frame_end (in_last_reg),
        .frame_sum (frame_sum)
    );

    psfc_result_reg u_res (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (step && in_last_reg),
        .frame_sum (frame_sum),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .result    (result)
    );

    assign m_tdata = {3'b000, result.battery_good, result.motion, result.tamper,
                      result.event_count, result.sensor_id, result.status};

endmodule
